>>> rtl/rsd_pkg.sv
// shared widths, constants and helpers for the stream seed derivation block
package rsd_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;
    localparam int BYTE_W = 8;
    localparam int CFG_ADDR_W = 2;

    // register indexes on the write port
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_SEED    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_SEED = 2'd1;

    localparam logic [WORD_W-1:0] FNV_BASIS  = 64'hCBF29CE484222325;
    localparam logic [WORD_W-1:0] FNV_PRIME  = 64'h00000100000001B3;
    localparam logic [WORD_W-1:0] GOLDEN_ADD = 64'h9E3779B97F4A7C15;
    localparam logic [WORD_W-1:0] FIN_MUL1   = 64'hBF58476D1CE4E5B9;
    localparam logic [WORD_W-1:0] FIN_MUL2   = 64'h94D049BB133111EB;
    localparam logic [WORD_W-1:0] INDEX_MUL  = 64'hD1342543DE82EF95;
    localparam logic [WORD_W-1:0] INC_TWEAK  = 64'h8C9E37F02E1A9C63;

    typedef logic [WORD_W-1:0] word_t;

    // zero is replaced by the substitute seed
    function automatic word_t nonzero_or(input word_t v, input word_t dflt);
        nonzero_or = (v == '0) ? dflt : v;
    endfunction

endpackage

>>> rtl/rsd_mul64.sv
// iterative 64x64 low-half multiplier built on one 32x32 multiplier
module rsd_mul64
    import rsd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  word_t a,
    input  word_t b,
    output logic  done,
    output word_t result
);

    localparam logic [1:0] PH_LL = 2'd0;
    localparam logic [1:0] PH_LH = 2'd1;
    localparam logic [1:0] PH_HL = 2'd2;
    localparam logic [1:0] PH_FIN = 2'd3;

    word_t a_reg, b_reg, prod_reg, acc_reg;
    logic [1:0] phase_reg;
    logic busy_reg, done_reg;
    logic [HALF_W-1:0] op_a, op_b;

    // operand selection for the three partial products that reach the low half
    always_comb begin
        op_a = (phase_reg == PH_HL) ? a_reg[WORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
        op_b = (phase_reg == PH_LH) ? b_reg[WORD_W-1:HALF_W] : b_reg[HALF_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= PH_LL;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_LL;
            end else if (busy_reg) begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == PH_FIN) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            b_reg <= b;
        end else if (busy_reg) begin
            prod_reg <= WORD_W'(op_a) * WORD_W'(op_b);
            case (phase_reg)
                PH_LL: ;
                PH_LH: acc_reg <= prod_reg;
                PH_HL, PH_FIN: acc_reg[WORD_W-1:HALF_W] <=
                    acc_reg[WORD_W-1:HALF_W] + prod_reg[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

>>> rtl/rng_stream_seed_derivation.sv
// stream seed derivation: fnv-1a tag hash, splitmix64 finalizer, seed mixing
// a byte that is not last holds the input while its fnv multiply runs; a last item goes
// through its byte multiply if any, the index multiply and the tag, seed1 and seed2 passes
// every multiply runs 4 passes through one shared 32x32 multiplier
// one item at a time; the result register frees the input side while it waits
// reset (synchronous, active low): idle, no result, hash at fnv basis, base 0, default 1
module rng_stream_seed_derivation
    import rsd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [WORD_W-1:0]     cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [71:0]           s_tdata,   // tag_byte [7:0], stream_index [71:8]
    input  logic                  s_tuser,   // byte_present
    input  logic                  s_tlast,   // last_byte
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [127:0]          m_tdata    // rng_state [63:0], rng_increment [127:64]
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_BYTE_MUL  = 4'd1;
    localparam logic [3:0] ST_BYTE_WAIT = 4'd2;
    localparam logic [3:0] ST_IDX_MUL   = 4'd3;
    localparam logic [3:0] ST_IDX_WAIT  = 4'd4;
    localparam logic [3:0] ST_FADD      = 4'd5;
    localparam logic [3:0] ST_FM1       = 4'd6;
    localparam logic [3:0] ST_FM1_WAIT  = 4'd7;
    localparam logic [3:0] ST_FM2       = 4'd8;
    localparam logic [3:0] ST_FM2_WAIT  = 4'd9;
    localparam logic [3:0] ST_FEND      = 4'd10;
    localparam logic [3:0] ST_OUT       = 4'd11;

    // which finalizer pass is running
    localparam logic [1:0] PASS_TAG   = 2'd0;
    localparam logic [1:0] PASS_SEED1 = 2'd1;
    localparam logic [1:0] PASS_SEED2 = 2'd2;

    logic [3:0] state_reg;
    logic [1:0] pass_reg;
    word_t base_seed_reg, default_seed_reg;
    word_t acc_reg;                 // fnv-1a accumulator
    logic [BYTE_W-1:0] byte_reg;
    logic last_reg;
    word_t index_reg;
    word_t idxm_reg;                // stream_index * odd constant
    word_t hash_reg;                // finalized tag hash
    word_t work_reg;                // finalizer working value
    word_t seed1_reg, seed2_reg;
    logic m_tvalid_reg;
    logic [127:0] m_tdata_reg;

    logic  mul_start, mul_done;
    word_t mul_a, mul_b, mul_res;
    word_t base_nz, fin_src, fin_out;
    logic  in_xfer;
    logic  out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // result register takes the new pair once it is free or being drained
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_seed_reg    <= '0;
            default_seed_reg <= WORD_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_BASE_SEED:    base_seed_reg    <= cfg_wdata;
                CFG_DEFAULT_SEED: default_seed_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // shared multiplier: operands follow the issuing state
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_BYTE_MUL: begin
                mul_start = 1'b1;
                mul_a     = acc_reg ^ WORD_W'(byte_reg);
                mul_b     = FNV_PRIME;
            end
            ST_IDX_MUL: begin
                mul_start = 1'b1;
                mul_a     = index_reg;
                mul_b     = INDEX_MUL;
            end
            ST_FM1: begin
                mul_start = 1'b1;
                mul_a     = work_reg ^ (work_reg >> 30);
                mul_b     = FIN_MUL1;
            end
            ST_FM2: begin
                mul_start = 1'b1;
                mul_a     = work_reg ^ (work_reg >> 27);
                mul_b     = FIN_MUL2;
            end
            default: ;
        endcase
    end

    rsd_mul64 u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    // finalizer input per pass, and its closing xor-shift
    always_comb begin
        base_nz = nonzero_or(base_seed_reg, default_seed_reg);
        case (pass_reg)
            PASS_TAG:   fin_src = acc_reg;
            PASS_SEED1: fin_src = base_nz ^ hash_reg ^ idxm_reg;
            default:    fin_src = base_nz ^ hash_reg ^ INC_TWEAK ^ idxm_reg;
        endcase
        fin_out = work_reg ^ (work_reg >> 31);
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pass_reg     <= PASS_TAG;
            acc_reg      <= FNV_BASIS;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (s_tuser) begin
                            state_reg <= ST_BYTE_MUL;
                        end else if (s_tlast) begin
                            state_reg <= ST_IDX_MUL;
                        end
                    end
                end
                ST_BYTE_MUL: state_reg <= ST_BYTE_WAIT;
                ST_BYTE_WAIT: begin
                    if (mul_done) begin
                        acc_reg   <= mul_res;
                        state_reg <= last_reg ? ST_IDX_MUL : ST_IDLE;
                    end
                end
                ST_IDX_MUL: state_reg <= ST_IDX_WAIT;
                ST_IDX_WAIT: begin
                    if (mul_done) begin
                        pass_reg  <= PASS_TAG;
                        state_reg <= ST_FADD;
                    end
                end
                ST_FADD: state_reg <= ST_FM1;
                ST_FM1: state_reg <= ST_FM1_WAIT;
                ST_FM1_WAIT: begin
                    if (mul_done) begin
                        state_reg <= ST_FM2;
                    end
                end
                ST_FM2: state_reg <= ST_FM2_WAIT;
                ST_FM2_WAIT: begin
                    if (mul_done) begin
                        state_reg <= ST_FEND;
                    end
                end
                ST_FEND: begin
                    case (pass_reg)
                        PASS_TAG: begin
                            pass_reg  <= PASS_SEED1;
                            state_reg <= ST_FADD;
                        end
                        PASS_SEED1: begin
                            pass_reg  <= PASS_SEED2;
                            state_reg <= ST_FADD;
                        end
                        default: state_reg <= ST_OUT;
                    endcase
                end
                ST_OUT: begin
                    // wait for the result register to free up
                    if (out_load) begin
                        acc_reg   <= FNV_BASIS;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            byte_reg  <= s_tdata[7:0];
            index_reg <= s_tdata[71:8];
            last_reg  <= s_tlast;
        end
        if (state_reg == ST_IDX_WAIT && mul_done) begin
            idxm_reg <= mul_res;
        end
        if (state_reg == ST_FADD) begin
            work_reg <= fin_src + GOLDEN_ADD;
        end
        if ((state_reg == ST_FM1_WAIT || state_reg == ST_FM2_WAIT) && mul_done) begin
            work_reg <= mul_res;
        end
        if (state_reg == ST_FEND) begin
            case (pass_reg)
                PASS_TAG:   hash_reg  <= fin_out;
                PASS_SEED1: seed1_reg <= nonzero_or(fin_out, default_seed_reg);
                default:    seed2_reg <= nonzero_or(fin_out, default_seed_reg);
            endcase
        end
        if (out_load) begin
            m_tdata_reg <= {seed2_reg[WORD_W-2:0], 1'b1, seed1_reg};
        end
    end

endmodule

>>> tb/sv/rng_stream_seed_derivation_tb.sv
// testbench for rng_stream_seed_derivation: tag bytes in, checked seed pairs out
`timescale 1ns / 100ps

module rng_stream_seed_derivation_tb
    import rsd_pkg::*;
();

    // cycles allowed after the last result before the block counts as idle
    localparam int SETTLE_CYCLES = 80;

    // write port indexes that decode to no register
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 2'd3;

    // one tag character transfer as the sender sees it
    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              has_byte;
        logic              is_last;
        word_t             stream_idx;
        bit                drain_first;  // hold off until no seed pair is outstanding
    } tag_item_t;

    // one derived generator seeding
    typedef struct packed {
        word_t incr;
        word_t state;
    } seed_pair_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_BASE_SEED;
    logic [WORD_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [71:0]           s_tdata = '0;   // tag_byte [7:0], stream_index [71:8]
    logic                  s_tuser = 1'b0; // byte_present
    logic                  s_tlast = 1'b0; // last_byte
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [127:0]          m_tdata;        // rng_state [63:0], rng_increment [127:64]

    // predictor copy of the block's registers and hash accumulator
    word_t      seed_base = '0;
    word_t      seed_fallback = 64'd1;
    word_t      fnv_acc = FNV_BASIS;

    tag_item_t  pending_tags[$];
    seed_pair_t expected_seeds[$];
    tag_item_t  drv_item;
    bit         drv_valid_next;
    int         gap_left = 0;
    int         stall_left = 0;
    bit         src_gaps_on = 1'b1;
    bit         sink_stalls_on = 1'b1;
    int         queued_n = 0;
    int         sent_n = 0;
    int         error_n = 0;

    rng_stream_seed_derivation DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // seed predictor
    // ------------------------------------------------------------------

    // splitmix64 output mix
    function automatic word_t splitmix_finish(input word_t v);
        word_t x;
        x = v + GOLDEN_ADD;
        x = (x ^ (x >> 30)) * FIN_MUL1;
        x = (x ^ (x >> 27)) * FIN_MUL2;
        return x ^ (x >> 31);
    endfunction

    function automatic word_t seed_or_fallback(input word_t v);
        return (v == '0) ? seed_fallback : v;
    endfunction

    // base seed, hash and scaled stream index mixed, then finished
    function automatic word_t mix_seed(input word_t hash, input word_t idx);
        word_t mixed;
        mixed = seed_or_fallback(seed_base) ^ hash ^ (idx * INDEX_MUL);
        return seed_or_fallback(splitmix_finish(mixed));
    endfunction

    // fold one accepted character; a last one closes the tag and yields a seed pair
    function automatic void fold_tag_item(input tag_item_t it);
        word_t      name_digest;
        word_t      second;
        seed_pair_t pair;
        if (it.has_byte)
            fnv_acc = (fnv_acc ^ {{(WORD_W-BYTE_W){1'b0}}, it.ch}) * FNV_PRIME;
        if (it.is_last) begin
            name_digest = splitmix_finish(fnv_acc);
            pair.state  = mix_seed(name_digest, it.stream_idx);
            second      = mix_seed(name_digest ^ INC_TWEAK, it.stream_idx);
            pair.incr   = {second[WORD_W-2:0], 1'b1};
            expected_seeds.push_back(pair);
            fnv_acc = FNV_BASIS;
        end
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_n++;
    endtask

    // ------------------------------------------------------------------
    // driver: presents queued characters, predicts on each transfer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            fnv_acc   = FNV_BASIS;
            gap_left  = 0;
        end else begin
            drv_valid_next = s_tvalid;
            if (s_tvalid && s_tready) begin
                fold_tag_item(drv_item);
                sent_n++;
                drv_valid_next = 1'b0;
            end
            if (!drv_valid_next) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_tags.size() != 0 &&
                             !(pending_tags[0].drain_first && expected_seeds.size() != 0)) begin
                    drv_item       = pending_tags.pop_front();
                    drv_valid_next = 1'b1;
                    gap_left       = pick_gap(src_gaps_on);
                    s_tdata <= {drv_item.stream_idx, drv_item.ch};
                    s_tuser <= drv_item.has_byte;
                    s_tlast <= drv_item.is_last;
                end
            end
            // valid stays high while a transfer is waiting for ready
            s_tvalid <= drv_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // monitor: random backpressure, compares each result transfer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_seeds.size() == 0) begin
                    flag_error($sformatf("seed pair %h with nothing outstanding", m_tdata));
                end else begin
                    if (m_tdata[WORD_W-1:0] !== expected_seeds[0].state)
                        flag_error($sformatf("rng_state got %h want %h",
                                             m_tdata[WORD_W-1:0], expected_seeds[0].state));
                    if (m_tdata[2*WORD_W-1:WORD_W] !== expected_seeds[0].incr)
                        flag_error($sformatf("rng_increment got %h want %h",
                                             m_tdata[2*WORD_W-1:WORD_W],
                                             expected_seeds[0].incr));
                    void'(expected_seeds.pop_front());
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (sink_stalls_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap(1'b1);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_char(input logic [BYTE_W-1:0] ch, input logic has_byte,
                              input logic is_last, input word_t idx,
                              input bit drain = 1'b0);
        tag_item_t it;
        it.ch          = ch;
        it.has_byte    = has_byte;
        it.is_last     = is_last;
        it.stream_idx  = idx;
        it.drain_first = drain;
        pending_tags.push_back(it);
        queued_n++;
    endtask

    function automatic word_t pick_stream_index();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return word_t'($urandom_range(0, 15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // register writes only happen while the block is idle
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input word_t val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_BASE_SEED)
            seed_base = val;
        else if (idx == CFG_DEFAULT_SEED)
            seed_fallback = val;
    endtask

    // every queued character sent, every seed pair back, then let the block settle
    task automatic wait_drained();
        do
            @(posedge aclk);
        while (sent_n != queued_n || expected_seeds.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly complete tags with random text; some stray empty characters and
    // tags closed by an empty last character
    task automatic queue_random_tags(input int n_chars);
        int made;
        int len;
        int r;
        bit drain;
        made = 0;
        while (made < n_chars) begin
            r     = $urandom_range(0, 99);
            drain = ($urandom_range(0, 19) == 0);
            if (r < 8) begin
                // ignored by the block, so not counted
                queue_char(8'($urandom), 1'b0, 1'b0, pick_stream_index(), drain);
            end else if (r < 12) begin
                queue_char(8'($urandom), 1'b0, 1'b1, pick_stream_index(), drain);
                made++;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24)
                                                  : $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    if (i != 0 && $urandom_range(0, 29) == 0)
                        queue_char(8'($urandom), 1'b0, 1'b0, pick_stream_index());
                    queue_char(8'($urandom), 1'b1, 1'b0, pick_stream_index(),
                               (i == 0) && drain);
                end
                // close with a present byte, or sometimes with an empty last character
                if ($urandom_range(0, 5) == 0)
                    queue_char(8'($urandom), 1'b0, 1'b1, pick_stream_index());
                else
                    queue_char(8'($urandom), 1'b1, 1'b1, pick_stream_index());
                made += len + 1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset register values: base 0 falls back to default 1
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        // empty tag, byte field ignored when absent
        queue_char(8'h00, 1'b0, 1'b1, '0);
        queue_char(8'hFF, 1'b0, 1'b1, '1);
        // single byte extremes
        queue_char(8'h00, 1'b1, 1'b1, '1);
        queue_char(8'hFF, 1'b1, 1'b1, 64'h8000_0000_0000_0000);
        // an empty non-last character in the middle changes nothing
        queue_char(8'h41, 1'b1, 1'b0, '1);
        queue_char(8'hFF, 1'b0, 1'b0, '1);
        queue_char(8'h42, 1'b1, 1'b1, 64'd1);
        // bytes closed by an empty last character
        queue_char(8'h10, 1'b1, 1'b0, '0);
        queue_char(8'h20, 1'b1, 1'b0, '0);
        queue_char(8'hC3, 1'b0, 1'b1, 64'h0123_4567_89AB_CDEF);
        // alternating bit patterns in the byte and index
        queue_char(8'hAA, 1'b1, 1'b0, 64'h5555_5555_5555_5555);
        queue_char(8'h55, 1'b1, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_char(8'h7F, 1'b1, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_char(8'h80, 1'b1, 1'b1, 64'h5555_5555_5555_5555, 1'b1);
        queue_random_tags(60);
        wait_drained();

        // both registers at their maximum, no idling on either side
        write_reg(CFG_BASE_SEED, '1);
        write_reg(CFG_DEFAULT_SEED, '1);
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        queue_char(8'h00, 1'b0, 1'b1, '0);
        queue_char(8'h61, 1'b1, 1'b1, '1);
        queue_random_tags(100);
        wait_drained();

        // zero substitute seed: a zero base seed stays zero in the mix
        write_reg(CFG_BASE_SEED, '0);
        write_reg(CFG_DEFAULT_SEED, '0);
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        queue_char(8'h00, 1'b0, 1'b1, '0);
        queue_char(8'h00, 1'b1, 1'b1, '0);
        queue_random_tags(60);
        wait_drained();

        // writes to the spare indexes must leave both registers alone
        write_reg(CFG_BASE_SEED, {$urandom, $urandom});
        write_reg(CFG_DEFAULT_SEED, {$urandom, $urandom});
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '0);
        write_reg(CFG_SPARE_A, {$urandom, $urandom});
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b1;
        queue_char(8'h5A, 1'b1, 1'b1, '1, 1'b1);
        queue_random_tags(100);
        wait_drained();

        // smallest nonzero base seed
        write_reg(CFG_BASE_SEED, 64'd1);
        write_reg(CFG_DEFAULT_SEED, {$urandom, $urandom});
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b0;
        queue_random_tags(140);
        wait_drained();

        // random base seed with the reset substitute, idling on both sides
        write_reg(CFG_BASE_SEED, {$urandom, $urandom});
        write_reg(CFG_DEFAULT_SEED, 64'd1);
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        queue_random_tags(140);
        wait_drained();

        if (error_n == 0)
            $display("rng_stream_seed_derivation_tb passed");
        else
            $display("rng_stream_seed_derivation_tb failed");
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial begin
        #(20_000_000);
        $display("rng_stream_seed_derivation_tb failed");
        $finish;
    end

endmodule
